[rtl/core/sha256_pkg.sv]
`timescale 1ns / 1ps
package sha256_pkg;

  localparam int unsigned BlockBytes = 64;
  localparam int unsigned Rounds = 64;
  localparam int unsigned CountWidth = 61;
  localparam logic [7:0] PadMark = 8'h80;
  localparam int unsigned QueueDepth = 4;

  typedef logic [31:0] word_t;

  // front to back request: one message byte or a finish
  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
  } req_t;

  typedef struct packed {
    word_t      digest_word;
    logic [2:0] word_index;
    logic       last_word;
  } res_t;

  localparam word_t InitH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic word_t round_k(input logic [5:0] t);
    word_t k [64];
    k = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };
    return k[t];
  endfunction

  function automatic word_t rotr(input word_t x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

[rtl/core/sha256_if.sv]
`timescale 1ns / 1ps
interface sha256_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data_byte;
  modport source (output valid, kind, data_byte, input ready);
  modport sink (input valid, kind, data_byte, output ready);
endinterface

interface sha256_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

[rtl/core/sha256_hasher.sv]
`timescale 1ns / 1ps
// a byte is stored while idle; a byte that completes a block then runs the load, round and add states
// a finish pads to the block end, runs one or two compressions,
// then emits 8 digest words, one per cycle while the sink is ready
// throughput is set by the single round unit: one round per cycle, 64 rounds per block
// a 4-entry queue lets bytes arrive while a block compresses
// synchronous reset loads the initial hash values and clears the byte count
module sha256_hasher (
  input  logic      clk,
  input  logic      rst,
  sha256_in_if.sink    in_ch,
  sha256_out_if.source out_ch
);

  logic             req_valid;
  logic             req_ready;
  sha256_pkg::req_t req;

  sha256_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .req_valid (req_valid),
    .req       (req),
    .req_ready (req_ready)
  );

  sha256_back u_back (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req       (req),
    .req_ready (req_ready),
    .out_ch    (out_ch)
  );

endmodule

[rtl/core/sha256_front.sv]
`timescale 1ns / 1ps
module sha256_front (
  input  logic               clk,
  input  logic               rst,
  sha256_in_if.sink          in_ch,
  output logic               req_valid,
  output sha256_pkg::req_t   req,
  input  logic               req_ready
);

  localparam int unsigned AW = $clog2(sha256_pkg::QueueDepth);

  sha256_pkg::req_t q [sha256_pkg::QueueDepth];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   fill;
  logic push;
  logic pop;

  assign in_ch.ready = (fill != (AW+1)'(sha256_pkg::QueueDepth));
  assign push = in_ch.valid && in_ch.ready;
  assign req_valid = (fill != '0);
  assign pop = req_valid && req_ready;
  assign req = q[rd_ptr];

  // classify and store incoming transactions
  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr].kind <= in_ch.kind;
      q[wr_ptr].data_byte <= in_ch.kind ? 8'h00 : in_ch.data_byte;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + AW'(1);
      if (pop) rd_ptr <= rd_ptr + AW'(1);
      fill <= fill + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

endmodule

[rtl/core/sha256_back.sv]
`timescale 1ns / 1ps
module sha256_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  input  sha256_pkg::req_t   req,
  output logic               req_ready,
  sha256_out_if.source       out_ch
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PAD   = 3'd1;
  localparam logic [2:0] S_LOAD  = 3'd2;
  localparam logic [2:0] S_ROUND = 3'd3;
  localparam logic [2:0] S_ADD   = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  logic [2:0] state;
  // block buffer held as 16 big-endian words, written one byte lane at a time
  sha256_pkg::word_t blk [sha256_pkg::BlockBytes / 4];
  logic [sha256_pkg::CountWidth-1:0] byte_count;
  logic [5:0] pos;
  logic [5:0] rnd;
  logic [3:0] ld;
  logic finishing;
  logic last_block;
  logic [2:0] emit_idx;
  sha256_pkg::word_t h [8];
  sha256_pkg::word_t v [8];
  sha256_pkg::word_t w [16];
  sha256_pkg::word_t wt;
  sha256_pkg::word_t w_new;
  sha256_pkg::word_t t1;
  sha256_pkg::word_t t2;
  sha256_pkg::word_t s0;
  sha256_pkg::word_t s1;
  logic [63:0] bits;
  logic [7:0] pad_byte;

  assign req_ready = (state == S_IDLE);
  assign bits = {byte_count, 3'b000};

  // padding byte for the current fill position
  always_comb begin
    pad_byte = 8'h00;
    if (pos >= 6'd56 && last_block)
      pad_byte = bits[8'(63 - 8 * 32'(pos - 6'd56)) -: 8];
  end

  // message schedule and round function
  always_comb begin
    s0 = sha256_pkg::rotr(w[1], 7) ^ sha256_pkg::rotr(w[1], 18) ^ (w[1] >> 3);
    s1 = sha256_pkg::rotr(w[14], 17) ^ sha256_pkg::rotr(w[14], 19) ^ (w[14] >> 10);
    w_new = s1 + w[9] + s0 + w[0];
    wt = w[0];
    t1 = v[7] + (sha256_pkg::rotr(v[4], 6) ^ sha256_pkg::rotr(v[4], 11)
         ^ sha256_pkg::rotr(v[4], 25)) + ((v[4] & v[5]) ^ (~v[4] & v[6]))
         + sha256_pkg::round_k(rnd) + wt;
    t2 = (sha256_pkg::rotr(v[0], 2) ^ sha256_pkg::rotr(v[0], 13)
         ^ sha256_pkg::rotr(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
  end

  // block buffer writes
  always_ff @(posedge clk) begin
    if (state == S_IDLE && req_valid) begin
      blk[pos[5:2]][{~pos[1:0], 3'b000} +: 8] <=
        req.kind ? sha256_pkg::PadMark : req.data_byte;
    end else if (state == S_PAD) begin
      blk[pos[5:2]][{~pos[1:0], 3'b000} +: 8] <= pad_byte;
    end
  end

  // schedule window and working variables
  always_ff @(posedge clk) begin
    if (state == S_LOAD) begin
      for (int i = 0; i < 15; i++) w[i] <= w[i+1];
      w[15] <= blk[ld];
      for (int i = 0; i < 8; i++) v[i] <= h[i];
    end else if (state == S_ROUND) begin
      for (int i = 0; i < 15; i++) w[i] <= w[i+1];
      w[15] <= w_new;
      v[7] <= v[6];
      v[6] <= v[5];
      v[5] <= v[4];
      v[4] <= v[3] + t1;
      v[3] <= v[2];
      v[2] <= v[1];
      v[1] <= v[0];
      v[0] <= t1 + t2;
    end
  end

  // control sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      byte_count <= '0;
      pos <= '0;
      rnd <= '0;
      ld <= '0;
      finishing <= 1'b0;
      last_block <= 1'b0;
      emit_idx <= '0;
      for (int i = 0; i < 8; i++) h[i] <= sha256_pkg::InitH[i];
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            if (!req.kind) begin
              byte_count <= byte_count + 61'd1;
              pos <= pos + 6'd1;
              finishing <= 1'b0;
              if (pos == 6'd63) begin
                ld <= '0;
                state <= S_LOAD;
              end
            end else begin
              finishing <= 1'b1;
              last_block <= (pos < 6'd56);
              pos <= pos + 6'd1;
              state <= (pos == 6'd63) ? S_LOAD : S_PAD;
              ld <= '0;
            end
          end
        end
        S_PAD: begin
          pos <= pos + 6'd1;
          if (pos == 6'd63) begin
            ld <= '0;
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          ld <= ld + 4'd1;
          if (ld == 4'd15) begin
            rnd <= '0;
            state <= S_ROUND;
          end
        end
        S_ROUND: begin
          rnd <= rnd + 6'd1;
          if (rnd == 6'd63) state <= S_ADD;
        end
        S_ADD: begin
          for (int i = 0; i < 8; i++) h[i] <= h[i] + v[i];
          if (!finishing) state <= S_IDLE;
          else if (!last_block) begin
            last_block <= 1'b1;
            state <= S_PAD;
          end else begin
            emit_idx <= '0;
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_ch.ready) begin
            emit_idx <= emit_idx + 3'd1;
            if (emit_idx == 3'd7) begin
              for (int i = 0; i < 8; i++) h[i] <= sha256_pkg::InitH[i];
              byte_count <= '0;
              pos <= '0;
              finishing <= 1'b0;
              last_block <= 1'b0;
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid = (state == S_EMIT);
  assign out_ch.digest_word = h[emit_idx];
  assign out_ch.word_index = emit_idx;
  assign out_ch.last_word = (emit_idx == 3'd7);

endmodule
